// File: rtl/core/brh_pkg.sv
package brh_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned POS_W = 3;
    localparam int unsigned PREFIX_LEN = 6;

    localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};

    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DASH = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

    // state handed over at the final character
    typedef struct packed {
        logic               pre_ok;
        logic               second_seen;
        logic [VALUE_W-1:0] first_value;
        logic [VALUE_W-1:0] second_value;
    } brh_final_t;

    function automatic logic [CHAR_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            3'd0: ch = 8'h62; // b
            3'd1: ch = 8'h79; // y
            3'd2: ch = 8'h74; // t
            3'd3: ch = 8'h65; // e
            3'd4: ch = 8'h73; // s
            3'd5: ch = 8'h3D; // =
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/core/brh_parse.sv
module brh_parse (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [brh_pkg::CHAR_W-1:0]        s_char_code,
    input  logic                              s_last_char,
    output logic                              fin_valid,
    input  logic                              fin_ready,
    output brh_pkg::brh_final_t               fin_data
);

    logic                          in_valid_reg;
    logic [brh_pkg::CHAR_W-1:0]    char_reg;
    logic                          last_reg;

    logic [1:0]                    phase_reg, phase_next;
    logic [brh_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic                          failed_reg, failed_next;
    logic [brh_pkg::VALUE_W-1:0]   first_reg, first_next;
    logic                          first_seen_reg, first_seen_next;
    logic [brh_pkg::VALUE_W-1:0]   second_reg, second_next;
    logic                          second_seen_reg, second_seen_next;
    logic                          content_reg, content_next;
    logic                          gap_reg, gap_next;

    logic                          fin_valid_reg;
    brh_pkg::brh_final_t           fin_reg;

    logic                          fin_free;
    logic                          advance;
    logic                          is_digit;
    logic                          is_other_ws;
    logic [brh_pkg::CHAR_W-1:0]    lc;
    logic [3:0]                    digit;
    logic [brh_pkg::VALUE_W-1:0]   acc_in;
    logic [brh_pkg::VALUE_W+3:0]   acc_sum;
    logic                          acc_ovf;
    logic                          fail_c;

    assign fin_free = !fin_valid_reg || fin_ready;
    assign advance = in_valid_reg && (!last_reg || fin_free);
    assign s_ready = !in_valid_reg || advance;
    assign fin_valid = fin_valid_reg;
    assign fin_data = fin_reg;

    assign is_digit = (char_reg >= brh_pkg::CH_ZERO) && (char_reg <= brh_pkg::CH_NINE);
    assign is_other_ws = (char_reg >= brh_pkg::CH_TAB) && (char_reg <= brh_pkg::CH_CR);
    assign lc = ((char_reg >= brh_pkg::CH_UPPER_A) && (char_reg <= brh_pkg::CH_UPPER_Z))
                ? (char_reg + 8'd32) : char_reg;
    assign digit = char_reg[3:0];

    // times-ten accumulate, one shared adder for both numbers
    assign acc_in = (phase_reg == brh_pkg::PH_SECOND) ? second_reg : first_reg;
    assign acc_sum = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0}
                   + {{brh_pkg::VALUE_W{1'b0}}, digit};
    assign acc_ovf = |acc_sum[brh_pkg::VALUE_W+3:brh_pkg::VALUE_W];

    always_comb begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        failed_next = failed_reg;
        first_next = first_reg;
        first_seen_next = first_seen_reg;
        second_next = second_reg;
        second_seen_next = second_seen_reg;
        content_next = content_reg;
        gap_next = gap_reg;
        fail_c = failed_reg || gap_reg || (char_reg == brh_pkg::CH_COMMA);
        if (char_reg == brh_pkg::CH_SPACE) begin
            fail_c = failed_reg;
        end else if (is_other_ws) begin
            fail_c = failed_reg;
            if (content_reg) begin
                gap_next = 1'b1;
            end
        end else begin
            content_next = 1'b1;
            failed_next = fail_c;
            if (!fail_c) begin
                case (phase_reg)
                    brh_pkg::PH_PREFIX: begin
                        if ((pos_reg < brh_pkg::POS_W'(brh_pkg::PREFIX_LEN))
                                && (lc == brh_pkg::prefix_char(pos_reg))) begin
                            pos_next = pos_reg + brh_pkg::POS_W'(1);
                            if (pos_reg == brh_pkg::POS_W'(brh_pkg::PREFIX_LEN - 1)) begin
                                phase_next = brh_pkg::PH_FIRST;
                            end
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    brh_pkg::PH_FIRST: begin
                        if (is_digit) begin
                            first_seen_next = 1'b1;
                            if (acc_ovf) begin
                                failed_next = 1'b1;
                            end else begin
                                first_next = acc_sum[brh_pkg::VALUE_W-1:0];
                            end
                        end else if ((char_reg == brh_pkg::CH_DASH) && first_seen_reg) begin
                            phase_next = brh_pkg::PH_SECOND;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    brh_pkg::PH_SECOND: begin
                        if (is_digit) begin
                            second_seen_next = 1'b1;
                            if (acc_ovf) begin
                                failed_next = 1'b1;
                            end else begin
                                second_next = acc_sum[brh_pkg::VALUE_W-1:0];
                            end
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    default: begin
                        failed_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            fin_valid_reg <= 1'b0;
            phase_reg <= brh_pkg::PH_PREFIX;
            pos_reg <= '0;
            failed_reg <= 1'b0;
            first_reg <= '0;
            first_seen_reg <= 1'b0;
            second_reg <= '0;
            second_seen_reg <= 1'b0;
            content_reg <= 1'b0;
            gap_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance && last_reg) begin
                fin_valid_reg <= 1'b1;
            end else if (fin_free) begin
                fin_valid_reg <= 1'b0;
            end
            if (advance) begin
                if (last_reg) begin
                    phase_reg <= brh_pkg::PH_PREFIX;
                    pos_reg <= '0;
                    failed_reg <= 1'b0;
                    first_reg <= '0;
                    first_seen_reg <= 1'b0;
                    second_reg <= '0;
                    second_seen_reg <= 1'b0;
                    content_reg <= 1'b0;
                    gap_reg <= 1'b0;
                end else begin
                    phase_reg <= phase_next;
                    pos_reg <= pos_next;
                    failed_reg <= failed_next;
                    first_reg <= first_next;
                    first_seen_reg <= first_seen_next;
                    second_reg <= second_next;
                    second_seen_reg <= second_seen_next;
                    content_reg <= content_next;
                    gap_reg <= gap_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            char_reg <= s_char_code;
            last_reg <= s_last_char;
        end
        if (advance && last_reg) begin
            fin_reg.pre_ok <= !failed_next && (phase_next == brh_pkg::PH_SECOND)
                              && first_seen_next;
            fin_reg.second_seen <= second_seen_next;
            fin_reg.first_value <= first_next;
            fin_reg.second_value <= second_next;
        end
    end

endmodule

// File: rtl/core/brh_judge.sv
module brh_judge (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              fin_valid,
    output logic                              fin_ready,
    input  brh_pkg::brh_final_t               fin_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_accepted,
    output logic [brh_pkg::VALUE_W-1:0]       m_first_byte,
    output logic [brh_pkg::VALUE_W-1:0]       m_last_byte,
    output logic                              m_open_ended
);

    logic                          m_valid_reg;
    logic                          accepted_reg;
    logic [brh_pkg::VALUE_W-1:0]   first_byte_reg;
    logic [brh_pkg::VALUE_W-1:0]   last_byte_reg;
    logic                          open_ended_reg;

    logic                          open_c;
    logic                          ok_c;

    assign fin_ready = !m_valid_reg || m_ready;

    assign open_c = !fin_data.second_seen || (fin_data.second_value == brh_pkg::ALL_ONES);
    assign ok_c = fin_data.pre_ok && (fin_data.first_value != brh_pkg::ALL_ONES)
                  && (open_c || (fin_data.first_value <= fin_data.second_value));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_ready) begin
            m_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_ready && fin_valid) begin
            accepted_reg <= ok_c;
            first_byte_reg <= ok_c ? fin_data.first_value : '0;
            last_byte_reg <= !ok_c ? '0
                           : (open_c ? brh_pkg::ALL_ONES : fin_data.second_value);
            open_ended_reg <= ok_c && open_c;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_accepted = accepted_reg;
    assign m_first_byte = first_byte_reg;
    assign m_last_byte = last_byte_reg;
    assign m_open_ended = open_ended_reg;

endmodule

// File: rtl/core/http_byte_range_header_parser.sv
// channel  direction  handshake          payload
// s_       in         s_valid / s_ready  s_char_code[7:0], s_last_char
// m_       out        m_valid / m_ready  m_accepted, m_first_byte[31:0],
//                                        m_last_byte[31:0], m_open_ended
//
// one character per cycle is taken while s_ready is high; each goes through an
// input register, one parse step and, for the final character, a range check
// stage and the result register.
// reset clears the parse state and all valid flags; the state also returns to
// its reset values after every final character.
// a stalled m_ready holds the result; s_ready drops only when a final character
// meets a full check stage.
module http_byte_range_header_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_last_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [31:0] m_first_byte,
    output logic [31:0] m_last_byte,
    output logic        m_open_ended
);

    logic                  fin_valid;
    logic                  fin_ready;
    brh_pkg::brh_final_t   fin_data;

    brh_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_last_char (s_last_char),
        .fin_valid   (fin_valid),
        .fin_ready   (fin_ready),
        .fin_data    (fin_data)
    );

    brh_judge u_judge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fin_valid    (fin_valid),
        .fin_ready    (fin_ready),
        .fin_data     (fin_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_accepted   (m_accepted),
        .m_first_byte (m_first_byte),
        .m_last_byte  (m_last_byte),
        .m_open_ended (m_open_ended)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_CHARS = 700;
    localparam logic [47:0] RANGE_UNIT = "bytes=";
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] CH_EQUALS = 8'h3D;

    typedef struct {
        logic        accepted;
        logic [31:0] first_byte;
        logic [31:0] last_byte;
        logic        open_ended;
    } byte_range_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_char_code;
    logic        s_last_char;
    logic        m_valid;
    logic        m_ready;
    logic        m_accepted;
    logic [31:0] m_first_byte;
    logic [31:0] m_last_byte;
    logic        m_open_ended;

    byte_range_t expected_ranges[$];
    logic [7:0]  header_buf[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned chars_sent = 0;
    bit          steady;

    // parser state as seen by the predictor
    logic [1:0]  pr_phase;
    logic [2:0]  pr_pos;
    logic        pr_failed;
    logic [31:0] pr_first;
    logic        pr_first_seen;
    logic [31:0] pr_second;
    logic        pr_second_seen;
    logic        pr_content;
    logic        pr_gap;

    http_byte_range_header_parser DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_code  (s_char_code),
        .s_last_char  (s_last_char),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_accepted   (m_accepted),
        .m_first_byte (m_first_byte),
        .m_last_byte  (m_last_byte),
        .m_open_ended (m_open_ended)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    function automatic int unsigned pick_gap();
        if (steady) begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic void clear_parse_state();
        pr_phase = brh_pkg::PH_PREFIX;
        pr_pos = '0;
        pr_failed = 1'b0;
        pr_first = '0;
        pr_first_seen = 1'b0;
        pr_second = '0;
        pr_second_seen = 1'b0;
        pr_content = 1'b0;
        pr_gap = 1'b0;
    endfunction

    task automatic parse_range_char(input logic [7:0] c, input logic last);
        logic [7:0]  lc;
        logic [63:0] acc;
        logic        open;
        byte_range_t r;
        if (c >= brh_pkg::CH_TAB && c <= brh_pkg::CH_CR) begin
            if (pr_content) begin
                pr_gap = 1'b1;
            end
        end else if (c != brh_pkg::CH_SPACE) begin
            if (pr_gap || c == brh_pkg::CH_COMMA) begin
                pr_failed = 1'b1;
            end
            pr_content = 1'b1;
            if (!pr_failed) begin
                case (pr_phase)
                    brh_pkg::PH_PREFIX: begin
                        lc = (c >= brh_pkg::CH_UPPER_A && c <= brh_pkg::CH_UPPER_Z)
                             ? c + 8'd32 : c;
                        if (pr_pos < brh_pkg::PREFIX_LEN &&
                            lc == RANGE_UNIT[8*(brh_pkg::PREFIX_LEN-1-pr_pos) +: 8]) begin
                            pr_pos++;
                            if (pr_pos == brh_pkg::PREFIX_LEN) begin
                                pr_phase = brh_pkg::PH_FIRST;
                            end
                        end else begin
                            pr_failed = 1'b1;
                        end
                    end
                    brh_pkg::PH_FIRST: begin
                        if (c >= brh_pkg::CH_ZERO && c <= brh_pkg::CH_NINE) begin
                            acc = pr_first * 64'd10 + 64'(c - brh_pkg::CH_ZERO);
                            if (acc > 64'(brh_pkg::ALL_ONES)) begin
                                pr_failed = 1'b1;
                            end else begin
                                pr_first = acc[31:0];
                            end
                            pr_first_seen = 1'b1;
                        end else if (c == brh_pkg::CH_DASH && pr_first_seen) begin
                            pr_phase = brh_pkg::PH_SECOND;
                        end else begin
                            pr_failed = 1'b1;
                        end
                    end
                    brh_pkg::PH_SECOND: begin
                        if (c >= brh_pkg::CH_ZERO && c <= brh_pkg::CH_NINE) begin
                            acc = pr_second * 64'd10 + 64'(c - brh_pkg::CH_ZERO);
                            if (acc > 64'(brh_pkg::ALL_ONES)) begin
                                pr_failed = 1'b1;
                            end else begin
                                pr_second = acc[31:0];
                            end
                            pr_second_seen = 1'b1;
                        end else begin
                            pr_failed = 1'b1;
                        end
                    end
                    default: begin
                        pr_failed = 1'b1;
                    end
                endcase
            end
        end
        if (last) begin
            open = !pr_second_seen || pr_second == brh_pkg::ALL_ONES;
            r.accepted = !pr_failed && pr_phase == brh_pkg::PH_SECOND && pr_first_seen &&
                         pr_first != brh_pkg::ALL_ONES && (open || pr_first <= pr_second);
            r.first_byte = r.accepted ? pr_first : '0;
            r.last_byte = r.accepted ? (open ? brh_pkg::ALL_ONES : pr_second) : '0;
            r.open_ended = r.accepted && open;
            expected_ranges.push_back(r);
            clear_parse_state();
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_char(input logic [7:0] c, input logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_char_code = c;
        s_last_char = last;
        do @(posedge aclk); while (!s_ready);
        parse_range_char(c, last);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_header();
        for (int i = 0; i < header_buf.size(); i++) begin
            send_char(header_buf[i], i == header_buf.size() - 1);
        end
    endtask

    task automatic push_string(input string t);
        for (int i = 0; i < t.len(); i++) begin
            header_buf.push_back(t[i]);
        end
    endtask

    task automatic send_text(input string t);
        header_buf.delete();
        push_string(t);
        send_header();
    endtask

    task automatic send_single(input logic [7:0] c);
        header_buf.delete();
        header_buf.push_back(c);
        send_header();
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (expected_ranges.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_blank();
        int unsigned n;
        n = $urandom_range(0, 5);
        return (n == 5) ? brh_pkg::CH_SPACE : brh_pkg::CH_TAB + n[7:0];
    endfunction

    function automatic logic [63:0] pick_offset();
        case ($urandom_range(0, 7))
            0: return 64'($urandom_range(0, 9));
            1: return 64'($urandom_range(0, 9999));
            2: return 64'($urandom);
            3: return 64'(brh_pkg::ALL_ONES);
            4: return 64'(brh_pkg::ALL_ONES) - 64'd1;
            5: return 64'h1_0000_0000 + 64'($urandom_range(0, 9));
            6: return {$urandom, $urandom};
            default: return 64'd0;
        endcase
    endfunction

    task automatic build_random_header();
        logic [63:0] first;
        logic [7:0]  c;
        int unsigned n;
        header_buf.delete();
        repeat ($urandom_range(0, 2)) header_buf.push_back(pick_blank());
        for (int i = 0; i < brh_pkg::PREFIX_LEN; i++) begin
            c = RANGE_UNIT[8*(brh_pkg::PREFIX_LEN-1-i) +: 8];
            if (c != CH_EQUALS && $urandom_range(0, 1)) begin
                c = c - 8'd32;
            end
            header_buf.push_back(c);
            if ($urandom_range(0, 9) == 0) begin
                header_buf.push_back(brh_pkg::CH_SPACE);
            end
        end
        first = pick_offset();
        if ($urandom_range(0, 9) == 0) begin
            header_buf.push_back(brh_pkg::CH_ZERO);
        end
        push_string($sformatf("%0d", first));
        if ($urandom_range(0, 7) == 0) begin
            header_buf.push_back(brh_pkg::CH_SPACE);
        end
        header_buf.push_back(brh_pkg::CH_DASH);
        case ($urandom_range(0, 3))
            0: ;
            1: push_string($sformatf("%0d", pick_offset()));
            2: push_string($sformatf("%0d", first + 64'($urandom_range(0, 1000))));
            default: push_string($sformatf("%0d", first - 64'($urandom_range(1, 3))));
        endcase
        repeat ($urandom_range(0, 2)) header_buf.push_back(pick_blank());
        // damage a quarter of the headers
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(0, header_buf.size() - 1);
            case ($urandom_range(0, 5))
                0: header_buf[n] = 8'($urandom_range(0, 255));
                1: header_buf.insert(n, brh_pkg::CH_COMMA);
                2: header_buf.insert(n, brh_pkg::CH_TAB + 8'($urandom_range(0, 4)));
                3: header_buf.insert(n, brh_pkg::CH_DASH);
                4: while (header_buf.size() > n + 1) void'(header_buf.pop_back());
                default: header_buf.delete(n);
            endcase
        end
    endtask

    task automatic send_noise();
        header_buf.delete();
        repeat ($urandom_range(1, 6)) header_buf.push_back(8'($urandom_range(0, 255)));
        send_header();
    endtask

    task automatic test_directed_headers();
        send_text("bytes=0-0");
        send_text("BYTES=0-");
        send_text("ByTeS=4294967294-4294967295");
        send_text("bytes=4294967295-");
        send_text("bytes=4294967295-4294967295");
        send_text("bytes=4294967296-");
        send_text("bytes=0-4294967296");
        send_text("bytes=5-3");
        send_text("bytes=3-5");
        send_text("bytes=7-7");
        send_text(" bytes = 1 - 2 ");
        send_text($sformatf("%cbytes=1-2%c%c ", brh_pkg::CH_TAB, brh_pkg::CH_CR, CH_LF));
        send_text($sformatf("bytes=1%c-2", brh_pkg::CH_TAB));
        send_text($sformatf("bytes=1-2%cx", CH_FF));
        send_text("bytes=1,2-3");
        send_text("bytes=-5");
        send_text("bytes=1--2");
        send_text("bytes=12");
        send_text("bytex=1-2");
        send_text("byte");
        send_text("bytes=1-2x");
        send_text($sformatf("bytes=0-%c", 8'hFF));
        send_single(8'h00);
        send_single(CH_LF);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        send_text("bytes=10-20");
        send_text("Bytes=123456-");
        send_text("bytes=99-98");
        send_text("bytes=0-4294967295");
        steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        send_text("bytes=42-4242");
        wait_drained();
        repeat (20) @(negedge aclk);
        send_text("bytes=8-");
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned stop_at;
        int unsigned headers;
        stop_at = chars_sent + RANDOM_CHARS;
        headers = 0;
        while (chars_sent < stop_at) begin
            if (headers % 8 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 6) == 0) begin
                send_noise();
            end else begin
                build_random_header();
                send_header();
            end
            headers++;
        end
        steady = 1'b0;
    endtask

    // result side: random back-pressure
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = pick_gap();
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        byte_range_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_ranges.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction, accepted=%0b first=%0d",
                                          m_accepted, m_first_byte));
            end else begin
                want = expected_ranges.pop_front();
                if (m_accepted !== want.accepted) begin
                    report_mismatch($sformatf("accepted %0b, want %0b",
                                              m_accepted, want.accepted));
                end
                if (m_first_byte !== want.first_byte) begin
                    report_mismatch($sformatf("first_byte %0d, want %0d",
                                              m_first_byte, want.first_byte));
                end
                if (m_last_byte !== want.last_byte) begin
                    report_mismatch($sformatf("last_byte %0d, want %0d",
                                              m_last_byte, want.last_byte));
                end
                if (m_open_ended !== want.open_ended) begin
                    report_mismatch($sformatf("open_ended %0b, want %0b",
                                              m_open_ended, want.open_ended));
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_char_code = '0;
        s_last_char = 1'b0;
        steady = 1'b0;
        clear_parse_state();
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        test_directed_headers();
        test_back_to_back();
        test_drain_pause();
        test_random_traffic();
        wait_drained();
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/brh_pkg.sv
rtl/core/brh_parse.sv
rtl/core/brh_judge.sv
rtl/core/http_byte_range_header_parser.sv
tb/testbench.sv
